// ===== sv/dgcd_pkg.sv =====
// shared types and constants of the deadlock graph cycle detector
package dgcd_pkg;

	localparam int KEY_W = 17;
	localparam int ID_W = 16;
	localparam int CODE_W = 8;
	localparam int NODES_W = 6;

	typedef enum logic [1:0] {
		OP_REQUEST  = 2'd0,
		OP_ALLOCATE = 2'd1,
		OP_RELEASE  = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

endpackage

// ===== sv/dgcd_req_if.sv =====
// operation channel of the deadlock graph cycle detector
interface dgcd_req_if;
	logic                          valid;
	logic                          ready;
	dgcd_pkg::op_t                 op;
	logic [dgcd_pkg::ID_W-1:0]     process_id;
	logic [dgcd_pkg::CODE_W-1:0]   resource_code;

	modport source (output valid, output op, output process_id, output resource_code,
		input ready);
	modport sink (input valid, input op, input process_id, input resource_code,
		output ready);
endinterface

// ===== sv/dgcd_rsp_if.sv =====
// result channel of the deadlock graph cycle detector
interface dgcd_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           deadlock;
	dgcd_pkg::status_t              status;
	logic [dgcd_pkg::NODES_W-1:0]   nodes_used;

	modport source (output valid, output deadlock, output status, output nodes_used,
		input ready);
	modport sink (input valid, input deadlock, input status, input nodes_used,
		output ready);
endinterface

// ===== sv/dgcd_ram.sv =====
// generic single write port ram with registered read
module dgcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/deadlock_graph_cycle_detector.sv =====
// top level: node table, adjacency matrix and depth-first cycle walk
// One operation is taken at a time and answered with one result. An operation other than a
// clear first scans the node table, reading and comparing each stored node, then, unless it
// fails, creates missing nodes and updates edges, then walks the graph depth-first. A row is
// read through the read port of the matrix ram into a register whenever its node is entered
// or resumed, and one adjacency bit of it is tested per cycle. Rows of the matrix carry valid
// bits that reset and clear drop at once, so there is no clearing pass.
module deadlock_graph_cycle_detector #(
	parameter int NODE_SLOTS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	dgcd_req_if.sink   req,
	dgcd_rsp_if.source rsp
);
	localparam int IW = $clog2(NODE_SLOTS);
	localparam int CW = $clog2(NODE_SLOTS + 1);
	localparam int SW = IW + CW;
	localparam int KW = dgcd_pkg::KEY_W;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_LK_RD  = 16'h0002,
		S_LK_CMP = 16'h0004,
		S_DECIDE = 16'h0008,
		S_NEW_P  = 16'h0010,
		S_NEW_R  = 16'h0020,
		S_E1_RD  = 16'h0040,
		S_E1_WR  = 16'h0080,
		S_E2_RD  = 16'h0100,
		S_E2_WR  = 16'h0200,
		S_W_INIT = 16'h0400,
		S_W_ROOT = 16'h0800,
		S_W_LOAD = 16'h1000,
		S_W_SCAN = 16'h2000,
		S_W_POP  = 16'h4000,
		S_DONE   = 16'h8000
	} state_t;

	state_t              state_q;
	dgcd_pkg::op_t       op_q;
	dgcd_pkg::status_t   status_q;
	logic [KW-1:0]       pkey_q;
	logic [KW-1:0]       rkey_q;
	logic [CW-1:0]       la_q;
	logic                p_found_q;
	logic                r_found_q;
	logic [IW-1:0]       p_idx_q;
	logic [IW-1:0]       r_idx_q;
	logic [CW-1:0]       total_q;
	logic [NODE_SLOTS-1:0] row_valid_q;
	logic                mat_vld_q;
	logic [CW-1:0]       root_q;
	logic [IW-1:0]       v_q;
	logic [CW-1:0]       nxt_q;
	logic [CW-1:0]       sp_q;
	logic [NODE_SLOTS-1:0] row_q;
	logic [NODE_SLOTS-1:0] visited_q;
	logic [NODE_SLOTS-1:0] onpath_q;
	logic                dead_q;
	logic                out_valid_q;
	logic                out_dead_q;
	dgcd_pkg::status_t   out_status_q;
	logic [dgcd_pkg::NODES_W-1:0] out_nodes_q;

	logic [CW:0]           need;
	logic                  full;
	logic [NODE_SLOTS-1:0] mat_rdata;
	logic [NODE_SLOTS-1:0] mat_row;
	logic [NODE_SLOTS-1:0] mat_wdata;
	logic [IW-1:0]         mat_raddr;
	logic [IW-1:0]         mat_waddr;
	logic                  mat_we;
	logic [NODE_SLOTS-1:0] p_bit;
	logic [NODE_SLOTS-1:0] r_bit;
	logic [KW-1:0]         node_rdata;
	logic [KW-1:0]         node_wdata;
	logic                  node_we;
	logic [IW-1:0]         total_idx;
	logic [IW-1:0]         root_idx;
	logic [IW-1:0]         u_idx;
	logic                  scan_more;
	logic                  push;
	logic [CW-1:0]         sp_m1;
	logic [CW-1:0]         sp_m2;
	logic [SW-1:0]         stk_rdata;
	logic [SW-1:0]         stk_wdata;
	logic [IW-1:0]         stk_v;
	logic [CW-1:0]         stk_nxt;

	assign need = (CW+1)'(!p_found_q) + (CW+1)'(!r_found_q);
	assign full = ({1'b0, total_q} + need) > (CW+1)'(NODE_SLOTS);
	assign mat_row = mat_vld_q ? mat_rdata : '0;
	assign p_bit = NODE_SLOTS'(1) << p_idx_q;
	assign r_bit = NODE_SLOTS'(1) << r_idx_q;
	assign total_idx = total_q[IW-1:0];
	assign root_idx = root_q[IW-1:0];
	assign u_idx = nxt_q[IW-1:0];
	assign scan_more = nxt_q < total_q;
	assign push = (state_q == S_W_SCAN) && scan_more && row_q[u_idx] && !onpath_q[u_idx]
		&& !visited_q[u_idx];
	assign sp_m1 = sp_q - CW'(1);
	assign sp_m2 = sp_q - CW'(2);
	assign stk_wdata = {v_q, nxt_q + CW'(1)};
	assign stk_v = stk_rdata[SW-1:CW];
	assign stk_nxt = stk_rdata[CW-1:0];

	// matrix port selection
	always_comb begin
		mat_we = (state_q == S_E1_WR) || (state_q == S_E2_WR);
		mat_waddr = (state_q == S_E1_WR) ? p_idx_q : r_idx_q;
		if (state_q == S_E1_WR) begin
			mat_wdata = (op_q == dgcd_pkg::OP_REQUEST) ? (mat_row | r_bit) : (mat_row & ~r_bit);
		end else begin
			mat_wdata = (op_q == dgcd_pkg::OP_ALLOCATE) ? (mat_row | p_bit) : (mat_row & ~p_bit);
		end
		case (state_q)
			S_E1_RD:  mat_raddr = p_idx_q;
			S_E2_RD:  mat_raddr = r_idx_q;
			S_W_ROOT: mat_raddr = root_idx;
			S_W_SCAN: mat_raddr = u_idx;
			S_W_POP:  mat_raddr = stk_v;
			default:  mat_raddr = p_idx_q;
		endcase
	end

	assign node_we = (state_q == S_NEW_P) || (state_q == S_NEW_R);
	assign node_wdata = (state_q == S_NEW_P) ? pkey_q : rkey_q;

	dgcd_ram #(.WIDTH(NODE_SLOTS), .DEPTH(NODE_SLOTS)) u_matrix (
		.clk   (clk),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata (mat_wdata),
		.raddr (mat_raddr),
		.rdata (mat_rdata)
	);

	dgcd_ram #(.WIDTH(KW), .DEPTH(NODE_SLOTS)) u_nodes (
		.clk   (clk),
		.we    (node_we),
		.waddr (total_idx),
		.wdata (node_wdata),
		.raddr (la_q[IW-1:0]),
		.rdata (node_rdata)
	);

	dgcd_ram #(.WIDTH(SW), .DEPTH(NODE_SLOTS)) u_stack (
		.clk   (clk),
		.we    (push),
		.waddr (sp_m1[IW-1:0]),
		.wdata (stk_wdata),
		.raddr (sp_m2[IW-1:0]),
		.rdata (stk_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		mat_vld_q <= row_valid_q[mat_raddr];
		if (state_q == S_W_LOAD) begin
			row_q <= mat_row;
		end
		if (state_q == S_IDLE && req.valid) begin
			op_q <= req.op;
			pkey_q <= {1'b0, req.process_id};
			rkey_q <= {1'b1, {(KW-1-dgcd_pkg::CODE_W){1'b0}}, req.resource_code};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= dgcd_pkg::ST_OK;
			la_q <= '0;
			p_found_q <= 1'b0;
			r_found_q <= 1'b0;
			p_idx_q <= '0;
			r_idx_q <= '0;
			total_q <= '0;
			row_valid_q <= '0;
			root_q <= '0;
			v_q <= '0;
			nxt_q <= '0;
			sp_q <= '0;
			visited_q <= '0;
			onpath_q <= '0;
			dead_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_dead_q <= 1'b0;
			out_status_q <= dgcd_pkg::ST_OK;
			out_nodes_q <= '0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						la_q <= '0;
						p_found_q <= 1'b0;
						r_found_q <= 1'b0;
						status_q <= dgcd_pkg::ST_OK;
						if (req.op == dgcd_pkg::OP_CLEAR) begin
							total_q <= '0;
							row_valid_q <= '0;
							state_q <= S_W_INIT;
						end else if (total_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_LK_RD;
						end
					end
				end
				S_LK_RD: state_q <= S_LK_CMP;
				S_LK_CMP: begin
					if (node_rdata == pkey_q) begin
						p_found_q <= 1'b1;
						p_idx_q <= la_q[IW-1:0];
					end
					if (node_rdata == rkey_q) begin
						r_found_q <= 1'b1;
						r_idx_q <= la_q[IW-1:0];
					end
					if (la_q + CW'(1) == total_q) begin
						state_q <= S_DECIDE;
					end else begin
						la_q <= la_q + CW'(1);
						state_q <= S_LK_RD;
					end
				end
				S_DECIDE: begin
					if (op_q == dgcd_pkg::OP_REQUEST) begin
						if (full) begin
							status_q <= dgcd_pkg::ST_FULL;
							state_q <= S_W_INIT;
						end else if (!p_found_q) begin
							state_q <= S_NEW_P;
						end else if (!r_found_q) begin
							state_q <= S_NEW_R;
						end else begin
							state_q <= S_E1_RD;
						end
					end else if (!(p_found_q && r_found_q)) begin
						status_q <= dgcd_pkg::ST_NOT_FOUND;
						state_q <= S_W_INIT;
					end else begin
						state_q <= S_E1_RD;
					end
				end
				S_NEW_P: begin
					row_valid_q[total_idx] <= 1'b0;
					p_idx_q <= total_idx;
					p_found_q <= 1'b1;
					total_q <= total_q + CW'(1);
					state_q <= r_found_q ? S_E1_RD : S_NEW_R;
				end
				S_NEW_R: begin
					row_valid_q[total_idx] <= 1'b0;
					r_idx_q <= total_idx;
					r_found_q <= 1'b1;
					total_q <= total_q + CW'(1);
					state_q <= S_E1_RD;
				end
				S_E1_RD: state_q <= S_E1_WR;
				S_E1_WR: begin
					row_valid_q[p_idx_q] <= 1'b1;
					state_q <= (op_q == dgcd_pkg::OP_REQUEST) ? S_W_INIT : S_E2_RD;
				end
				S_E2_RD: state_q <= S_E2_WR;
				S_E2_WR: begin
					row_valid_q[r_idx_q] <= 1'b1;
					state_q <= S_W_INIT;
				end
				S_W_INIT: begin
					visited_q <= '0;
					onpath_q <= '0;
					root_q <= '0;
					dead_q <= 1'b0;
					state_q <= S_W_ROOT;
				end
				S_W_ROOT: begin
					if (root_q == total_q) begin
						state_q <= S_DONE;
					end else if (visited_q[root_idx]) begin
						root_q <= root_q + CW'(1);
					end else begin
						v_q <= root_idx;
						nxt_q <= '0;
						sp_q <= CW'(1);
						visited_q[root_idx] <= 1'b1;
						onpath_q[root_idx] <= 1'b1;
						state_q <= S_W_LOAD;
					end
				end
				S_W_LOAD: state_q <= S_W_SCAN;
				S_W_SCAN: begin
					if (scan_more) begin
						if (row_q[u_idx] && onpath_q[u_idx]) begin
							dead_q <= 1'b1;
							state_q <= S_DONE;
						end else if (push) begin
							v_q <= u_idx;
							nxt_q <= '0;
							sp_q <= sp_q + CW'(1);
							visited_q[u_idx] <= 1'b1;
							onpath_q[u_idx] <= 1'b1;
							state_q <= S_W_LOAD;
						end else begin
							nxt_q <= nxt_q + CW'(1);
						end
					end else begin
						onpath_q[v_q] <= 1'b0;
						if (sp_q == CW'(1)) begin
							sp_q <= '0;
							root_q <= root_q + CW'(1);
							state_q <= S_W_ROOT;
						end else begin
							sp_q <= sp_m1;
							state_q <= S_W_POP;
						end
					end
				end
				S_W_POP: begin
					v_q <= stk_v;
					nxt_q <= stk_nxt;
					state_q <= S_W_LOAD;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_dead_q <= dead_q;
						out_status_q <= status_q;
						out_nodes_q <= dgcd_pkg::NODES_W'(total_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.deadlock = out_dead_q;
	assign rsp.status = out_status_q;
	assign rsp.nodes_used = out_nodes_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(NODE_SLOTS))
		else $error("node count beyond table size");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("operation taken while busy");

	a_stack_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_W_SCAN |-> sp_q != '0 && sp_q <= total_q)
		else $error("walk stack depth out of range");
endmodule

// ===== dv/dgcd_scoreboard.sv =====
// scoreboard for the deadlock graph cycle detector: graph predictor and result checking
`timescale 1ns / 100ps
class dgcd_scoreboard;
	typedef struct packed {
		logic                         deadlock;
		dgcd_pkg::status_t            status;
		logic [dgcd_pkg::NODES_W-1:0] nodes_used;
	} verdict_t;

	localparam int SLOTS = 32;

	logic [SLOTS-1:0]           adj [SLOTS];
	logic [dgcd_pkg::KEY_W-1:0] keys [SLOTS];
	int                         used_nodes;
	verdict_t                   pending [$];
	int                         errors;

	function new();
		graph_reset();
		errors = 0;
	endfunction

	function void graph_reset();
		for (int i = 0; i < SLOTS; i++) begin
			adj[i] = '0;
			keys[i] = '0;
		end
		used_nodes = 0;
	endfunction

	function int slot_of(logic [dgcd_pkg::KEY_W-1:0] key);
		for (int i = 0; i < used_nodes; i++)
			if (keys[i] == key)
				return i;
		return -1;
	endfunction

	function bit graph_has_loop();
		int path [SLOTS];
		int cursor [SLOTS];
		logic [SLOTS-1:0] seen;
		logic [SLOTS-1:0] live;
		int depth;
		int v;
		int u;
		seen = '0;
		live = '0;
		for (int root = 0; root < used_nodes; root++) begin
			if (seen[root])
				continue;
			depth = 0;
			path[depth] = root;
			depth = depth + 1;
			cursor[root] = 0;
			seen[root] = 1'b1;
			live[root] = 1'b1;
			while (depth > 0) begin
				v = path[depth-1];
				if (cursor[v] < used_nodes) begin
					u = cursor[v];
					cursor[v] = cursor[v] + 1;
					if (adj[v][u]) begin
						if (live[u])
							return 1'b1;
						if (!seen[u]) begin
							seen[u] = 1'b1;
							live[u] = 1'b1;
							cursor[u] = 0;
							path[depth] = u;
							depth = depth + 1;
						end
					end
				end else begin
					live[v] = 1'b0;
					depth = depth - 1;
				end
			end
		end
		return 1'b0;
	endfunction

	function void note_operation(dgcd_pkg::op_t op, logic [15:0] pid, logic [7:0] code);
		logic [dgcd_pkg::KEY_W-1:0] pkey;
		logic [dgcd_pkg::KEY_W-1:0] rkey;
		int p;
		int r;
		int need;
		verdict_t v;
		pkey = {1'b0, pid};
		rkey = {1'b1, 8'd0, code};
		v.status = dgcd_pkg::ST_OK;
		if (op == dgcd_pkg::OP_CLEAR) begin
			graph_reset();
		end else begin
			p = slot_of(pkey);
			r = slot_of(rkey);
			if (op == dgcd_pkg::OP_REQUEST) begin
				need = (p < 0) + (r < 0);
				if (used_nodes + need > SLOTS) begin
					v.status = dgcd_pkg::ST_FULL;
				end else begin
					if (p < 0) begin
						keys[used_nodes] = pkey;
						adj[used_nodes] = '0;
						p = used_nodes;
						used_nodes = used_nodes + 1;
					end
					if (r < 0) begin
						keys[used_nodes] = rkey;
						adj[used_nodes] = '0;
						r = used_nodes;
						used_nodes = used_nodes + 1;
					end
					adj[p][r] = 1'b1;
				end
			end else if (p < 0 || r < 0) begin
				v.status = dgcd_pkg::ST_NOT_FOUND;
			end else begin
				adj[p][r] = 1'b0;
				adj[r][p] = (op == dgcd_pkg::OP_ALLOCATE);
			end
		end
		v.deadlock = graph_has_loop();
		v.nodes_used = used_nodes[5:0];
		pending.push_back(v);
	endfunction

	task report(string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	task check_result(logic dl, dgcd_pkg::status_t st, logic [5:0] used);
		verdict_t e;
		if (pending.size() == 0) begin
			report("result with nothing expected");
			return;
		end
		e = pending.pop_front();
		if (dl !== e.deadlock)
			report($sformatf("deadlock %0b expected %0b", dl, e.deadlock));
		if (st !== e.status)
			report($sformatf("status %0d expected %0d", st, e.status));
		if (used !== e.nodes_used)
			report($sformatf("nodes_used %0d expected %0d", used, e.nodes_used));
	endtask
endclass

// ===== dv/tb_deadlock_graph_cycle_detector.sv =====
// testbench top for the deadlock graph cycle detector
`timescale 1ns / 100ps
module tb_deadlock_graph_cycle_detector;
	logic clk;
	logic arst_n;
	int   send_idle;
	int   sink_stall;
	int   pid_pool;
	int   code_pool;

	dgcd_req_if req ();
	dgcd_rsp_if rsp ();
	dgcd_scoreboard graph_sb;

	deadlock_graph_cycle_detector DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				graph_sb.check_result(rsp.deadlock, rsp.status, rsp.nodes_used);
			rsp.ready <= ($urandom_range(99) >= sink_stall);
		end else begin
			rsp.ready <= 1'b0;
		end
	end

	task send_op(dgcd_pkg::op_t op, logic [15:0] pid, logic [7:0] code);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.process_id <= pid;
		req.resource_code <= code;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		graph_sb.note_operation(op, pid, code);
	endtask

	task send_random();
		int k;
		dgcd_pkg::op_t op;
		logic [15:0] pid;
		logic [7:0] code;
		k = int'($urandom_range(99));
		if (k < 45)
			op = dgcd_pkg::OP_REQUEST;
		else if (k < 72)
			op = dgcd_pkg::OP_ALLOCATE;
		else if (k < 97)
			op = dgcd_pkg::OP_RELEASE;
		else
			op = dgcd_pkg::OP_CLEAR;
		if ($urandom_range(9) == 0) begin
			pid = 16'($urandom);
			code = 8'($urandom);
		end else begin
			pid = (16'hA5C0 ^ {4'($urandom_range(15)), 12'h000})
				+ 16'($urandom_range(pid_pool));
			code = 8'h3C + 8'($urandom_range(code_pool));
		end
		send_op(op, pid, code);
	endtask

	task drain();
		req.valid <= 1'b0;
		while (graph_sb.pending.size() != 0)
			@(posedge clk);
		repeat (1400)
			@(posedge clk);
	endtask

	initial begin
		req.valid = 1'b0;
		req.op = dgcd_pkg::OP_CLEAR;
		req.process_id = '0;
		req.resource_code = '0;
		send_idle = 0;
		sink_stall = 0;
		graph_sb = new();
		arst_n = 1'b0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(dgcd_pkg::OP_ALLOCATE, 16'h0000, 8'h00);
		send_op(dgcd_pkg::OP_RELEASE, 16'hFFFF, 8'hFF);
		send_op(dgcd_pkg::OP_REQUEST, 16'h0000, 8'h00);
		send_op(dgcd_pkg::OP_REQUEST, 16'hFFFF, 8'hFF);
		send_op(dgcd_pkg::OP_ALLOCATE, 16'h0000, 8'h00);
		send_op(dgcd_pkg::OP_REQUEST, 16'hFFFF, 8'h00);
		send_op(dgcd_pkg::OP_ALLOCATE, 16'hFFFF, 8'hFF);
		send_op(dgcd_pkg::OP_REQUEST, 16'h0000, 8'hFF);
		send_op(dgcd_pkg::OP_RELEASE, 16'h0000, 8'hFF);
		send_op(dgcd_pkg::OP_RELEASE, 16'h1234, 8'h00);
		send_op(dgcd_pkg::OP_RELEASE, 16'h0000, 8'h77);
		send_op(dgcd_pkg::OP_CLEAR, 16'h5A5A, 8'hA5);
		for (int i = 0; i < 16; i++)
			send_op(dgcd_pkg::OP_REQUEST, 16'(i * 16'h1111), 8'(i));
		send_op(dgcd_pkg::OP_REQUEST, 16'hBEEF, 8'h00);
		send_op(dgcd_pkg::OP_REQUEST, 16'h0000, 8'hEE);
		send_op(dgcd_pkg::OP_REQUEST, 16'h0000, 8'h0F);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle = (phase == 1 || phase == 3) ? 53 : 0;
			sink_stall = (phase == 2) ? 53 : (phase == 3 ? 17 : 0);
			if (phase == 3)
				send_idle = 17;
			for (int n = 0; n < 140; n++) begin
				pid_pool = (n % 40 < 20) ? 3 : 11;
				code_pool = (n % 40 < 20) ? 3 : 12;
				send_random();
			end
			drain();
		end

		if (graph_sb.errors == 0)
			$display("** deadlock_graph_cycle_detector: PASSED **");
		else
			$display("** deadlock_graph_cycle_detector: FAILED **");
		$finish;
	end

	initial begin
		#8000000;
		$display("** deadlock_graph_cycle_detector: FAILED **");
		$finish;
	end
endmodule

// ===== deadlock_graph_cycle_detector.f =====
sv/dgcd_pkg.sv
sv/dgcd_req_if.sv
sv/dgcd_rsp_if.sv
sv/dgcd_ram.sv
sv/deadlock_graph_cycle_detector.sv
dv/dgcd_scoreboard.sv
dv/tb_deadlock_graph_cycle_detector.sv
